FILE: rtl/fucr_pkg.sv
// Shared constants, command table and types of the framed command recognizer.
package fucr_pkg;

    localparam int BUFFER_BYTES = 64;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int FC_W         = $clog2(BUFFER_BYTES + 2);
    localparam int BYTE_W       = 8;
    localparam int CMD_W        = 4;
    localparam int PLEN_W       = 6;
    localparam int CFG_IDX_W    = 1;
    localparam int NUM_CMDS     = 9;
    localparam int NUM_EXACT    = 6;
    localparam int TEXT_MAX     = 13;
    localparam int SCAN_LEN     = TEXT_MAX + 1;
    localparam int IDX_W        = $clog2(SCAN_LEN);

    localparam logic [BYTE_W-1:0] START_CHAR_RESET = 8'd60;
    localparam logic [BYTE_W-1:0] END_CHAR_RESET   = 8'd62;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_CHAR,
        REG_END_CHAR
    } cfg_reg_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_LED_ON,
        CMD_LED_OFF,
        CMD_BEEP_ON,
        CMD_BEEP_OFF,
        CMD_GET_DATETIME,
        CMD_GET_ALARM,
        CMD_SET_DATE,
        CMD_SET_TIME,
        CMD_SET_ALARM
    } cmd_t;

    localparam logic [8*TEXT_MAX-1:0] CMD_TEXT [NUM_CMDS] = '{
        (8*TEXT_MAX)'("led on"),
        (8*TEXT_MAX)'("led off"),
        (8*TEXT_MAX)'("beep on"),
        (8*TEXT_MAX)'("beep off"),
        (8*TEXT_MAX)'("get datetime"),
        (8*TEXT_MAX)'("get alarmtime"),
        (8*TEXT_MAX)'("set date"),
        (8*TEXT_MAX)'("set time"),
        (8*TEXT_MAX)'("set alarm")
    };

    localparam logic [IDX_W-1:0] CMD_LEN [NUM_CMDS] = '{
        4'd6, 4'd7, 4'd7, 4'd8, 4'd12, 4'd13, 4'd8, 4'd8, 4'd9
    };

    typedef struct packed {
        logic              vld;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
    } scan_t;

    typedef struct packed {
        logic              hit;
        cmd_t              cmd;
        logic [PLEN_W-1:0] plen;
        logic [ADDR_W-1:0] pos;
    } match_t;

endpackage

FILE: rtl/fucr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fucr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/fucr_match.sv
// Candidate flags narrowed one text position per cycle, priority pick and payload length.
module fucr_match (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     clear,
    input  fucr_pkg::scan_t          scan,
    input  logic [fucr_pkg::FC_W-1:0] frame_count,
    output fucr_pkg::match_t         result
);

    logic [fucr_pkg::NUM_CMDS-1:0] flags_reg;
    logic [fucr_pkg::NUM_CMDS-1:0] flags_next;
    logic [fucr_pkg::CMD_W-1:0]    found;
    logic                          hit;
    logic [fucr_pkg::FC_W-1:0]     need;

    always_comb begin
        logic [fucr_pkg::IDX_W-1:0]   pos;
        logic [fucr_pkg::IDX_W+2:0]   base;
        logic                         ok;
        pos        = '0;
        base       = '0;
        ok         = 1'b1;
        flags_next = flags_reg;
        if (clear) begin
            flags_next = '1;
        end else if (scan.vld) begin
            for (int c = 0; c < fucr_pkg::NUM_CMDS; c++) begin
                pos  = fucr_pkg::CMD_LEN[c] - 1'b1 - scan.idx;
                base = {pos, 3'b000};
                if (scan.idx < fucr_pkg::CMD_LEN[c]) begin
                    ok = (scan.data == fucr_pkg::CMD_TEXT[c][base +: fucr_pkg::BYTE_W]);
                end else if (c < fucr_pkg::NUM_EXACT && scan.idx == fucr_pkg::CMD_LEN[c]) begin
                    ok = (scan.data == '0);
                end else begin
                    ok = 1'b1;
                end
                flags_next[c] = flags_reg[c] & ok;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '1;
        end else begin
            flags_reg <= flags_next;
        end
    end

    always_comb begin
        hit   = 1'b0;
        found = '0;
        for (int c = fucr_pkg::NUM_CMDS - 1; c >= 0; c--) begin
            if (flags_reg[c]) begin
                hit   = 1'b1;
                found = fucr_pkg::CMD_W'(c);
            end
        end
    end

    assign need = fucr_pkg::FC_W'(fucr_pkg::CMD_LEN[found]) + 1'b1;

    always_comb begin
        result.hit  = hit;
        result.cmd  = fucr_pkg::cmd_t'(found);
        result.pos  = fucr_pkg::ADDR_W'(fucr_pkg::CMD_LEN[found]);
        result.plen = '0;
        if (found >= fucr_pkg::CMD_W'(fucr_pkg::NUM_EXACT) && frame_count >= need) begin
            result.plen = fucr_pkg::PLEN_W'(frame_count - need);
        end
    end

endmodule

FILE: rtl/framed_uart_command_recognizer_top.sv
// Top level: frame collection into the text RAM, command scan and payload streaming.
// Flow: in idle one byte is taken per cycle; the end byte starts the scan, drain and decide
// states, after which an exact result is loaded into the output register.
// Payload bytes then pass a RAM read state and an output load state each, plus m_ready stalls;
// input is held until the last result is loaded.
// Reset: closes any frame, chars return to '<' and '>'; a fill mark masks stale RAM text to zero.
module framed_uart_command_recognizer_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [fucr_pkg::BYTE_W-1:0]      s_rx_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [fucr_pkg::CMD_W-1:0]       m_command,
    output logic [fucr_pkg::PLEN_W-1:0]      m_payload_length,
    output logic [fucr_pkg::BYTE_W-1:0]      m_payload_byte,
    output logic                             m_last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fucr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fucr_pkg::BYTE_W-1:0]      cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_READ,
        ST_SEND
    } state_t;

    state_t                        state_reg, state_next;
    logic [fucr_pkg::BYTE_W-1:0]   start_char_reg, start_char_next;
    logic [fucr_pkg::BYTE_W-1:0]   end_char_reg, end_char_next;
    logic [fucr_pkg::FC_W-1:0]     fc_reg, fc_next;
    logic [fucr_pkg::FC_W-1:0]     hw_reg, hw_next;
    logic [fucr_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic                          scan_vld_reg, scan_vld_next;
    logic [fucr_pkg::IDX_W-1:0]    scan_idx_reg, scan_idx_next;
    logic [fucr_pkg::ADDR_W-1:0]   pos_reg, pos_next;
    logic [fucr_pkg::PLEN_W-1:0]   rem_reg, rem_next;
    logic [fucr_pkg::PLEN_W-1:0]   plen_reg, plen_next;
    logic [fucr_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic                          m_valid_reg, m_valid_next;
    logic [fucr_pkg::CMD_W-1:0]    m_command_reg, m_command_next;
    logic [fucr_pkg::PLEN_W-1:0]   m_payload_length_reg, m_payload_length_next;
    logic [fucr_pkg::BYTE_W-1:0]   m_payload_byte_reg, m_payload_byte_next;
    logic                          m_last_reg, m_last_next;

    logic                          in_fire;
    logic                          out_free;
    logic                          wr_en;
    logic [fucr_pkg::ADDR_W-1:0]   wr_addr;
    logic                          rd_en;
    logic [fucr_pkg::ADDR_W-1:0]   rd_addr;
    logic [fucr_pkg::BYTE_W-1:0]   rd_data;
    logic                          scan_clear;
    fucr_pkg::scan_t               scan;
    fucr_pkg::match_t              result;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign wr_en = in_fire && (s_rx_byte != start_char_reg) && (s_rx_byte != end_char_reg)
                   && (fc_reg != '0)
                   && (fc_reg <= fucr_pkg::FC_W'(fucr_pkg::BUFFER_BYTES));
    assign wr_addr = fucr_pkg::ADDR_W'(fc_reg - 1'b1);
    assign rd_en   = (state_reg == ST_SCAN) || (state_reg == ST_READ);
    assign rd_addr = (state_reg == ST_SCAN) ? fucr_pkg::ADDR_W'(idx_reg) : pos_reg;

    assign scan_clear = in_fire && (s_rx_byte != start_char_reg) && (s_rx_byte == end_char_reg);
    assign scan.vld   = scan_vld_reg;
    assign scan.idx   = scan_idx_reg;
    assign scan.data  = (fucr_pkg::FC_W'(scan_idx_reg) < hw_reg) ? rd_data : '0;

    fucr_ram #(
        .WIDTH(fucr_pkg::BYTE_W),
        .DEPTH(fucr_pkg::BUFFER_BYTES)
    ) u_text_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fucr_match u_match (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear       (scan_clear),
        .scan        (scan),
        .frame_count (fc_reg),
        .result      (result)
    );

    always_comb begin
        state_next            = state_reg;
        start_char_next       = start_char_reg;
        end_char_next         = end_char_reg;
        fc_next               = fc_reg;
        hw_next               = hw_reg;
        idx_next              = idx_reg;
        scan_vld_next         = 1'b0;
        scan_idx_next         = scan_idx_reg;
        pos_next              = pos_reg;
        rem_next              = rem_reg;
        plen_next             = plen_reg;
        cmd_next              = cmd_reg;
        m_valid_next          = m_valid_reg && !m_ready;
        m_command_next        = m_command_reg;
        m_payload_length_next = m_payload_length_reg;
        m_payload_byte_next   = m_payload_byte_reg;
        m_last_next           = m_last_reg;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                fucr_pkg::REG_START_CHAR: start_char_next = cfg_data;
                fucr_pkg::REG_END_CHAR:   end_char_next   = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_rx_byte == start_char_reg) begin
                        fc_next = fucr_pkg::FC_W'(1);
                    end else if (s_rx_byte == end_char_reg) begin
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end else if (wr_en) begin
                        fc_next = fc_reg + 1'b1;
                        if (fc_reg > hw_reg) begin
                            hw_next = fc_reg;
                        end
                    end
                end
            end
            ST_SCAN: begin
                scan_vld_next = 1'b1;
                scan_idx_next = idx_reg;
                idx_next      = idx_reg + 1'b1;
                if (idx_reg == fucr_pkg::IDX_W'(fucr_pkg::SCAN_LEN - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!result.hit) begin
                    fc_next    = '0;
                    hw_next    = '0;
                    state_next = ST_IDLE;
                end else if (result.plen == '0) begin
                    if (out_free) begin
                        m_valid_next          = 1'b1;
                        m_command_next        = result.cmd;
                        m_payload_length_next = '0;
                        m_payload_byte_next   = '0;
                        m_last_next           = 1'b1;
                        fc_next               = '0;
                        hw_next               = '0;
                        state_next            = ST_IDLE;
                    end
                end else begin
                    cmd_next   = result.cmd;
                    plen_next  = result.plen;
                    rem_next   = result.plen;
                    pos_next   = result.pos;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_command_next        = cmd_reg;
                    m_payload_length_next = plen_reg;
                    m_payload_byte_next   = rd_data;
                    m_last_next           = (rem_reg == fucr_pkg::PLEN_W'(1));
                    pos_next              = pos_reg + 1'b1;
                    rem_next              = rem_reg - 1'b1;
                    if (rem_reg == fucr_pkg::PLEN_W'(1)) begin
                        fc_next    = '0;
                        hw_next    = '0;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        idx_reg              <= idx_next;
        scan_idx_reg         <= scan_idx_next;
        pos_reg              <= pos_next;
        rem_reg              <= rem_next;
        plen_reg             <= plen_next;
        cmd_reg              <= cmd_next;
        m_command_reg        <= m_command_next;
        m_payload_length_reg <= m_payload_length_next;
        m_payload_byte_reg   <= m_payload_byte_next;
        m_last_reg           <= m_last_next;
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            start_char_reg <= fucr_pkg::START_CHAR_RESET;
            end_char_reg   <= fucr_pkg::END_CHAR_RESET;
            fc_reg         <= '0;
            hw_reg         <= '0;
            scan_vld_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            start_char_reg <= start_char_next;
            end_char_reg   <= end_char_next;
            fc_reg         <= fc_next;
            hw_reg         <= hw_next;
            scan_vld_reg   <= scan_vld_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_command        = m_command_reg;
    assign m_payload_length = m_payload_length_reg;
    assign m_payload_byte   = m_payload_byte_reg;
    assign m_last           = m_last_reg;

endmodule

FILE: rtl/fucr_check.sv
// Port-level checker for the command recognizer, bound to the top level.
module fucr_check (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [fucr_pkg::CMD_W-1:0]       m_command,
    input  logic [fucr_pkg::PLEN_W-1:0]      m_payload_length,
    input  logic [fucr_pkg::BYTE_W-1:0]      m_payload_byte,
    input  logic                             m_last
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_command) && $stable(m_payload_length)
            && $stable(m_payload_byte) && $stable(m_last))
        else $error("result changed while stalled");

    a_cmd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_command <= fucr_pkg::CMD_W'(fucr_pkg::CMD_SET_ALARM))
        else $error("command code out of range");

    a_empty_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload_length == '0 |-> m_last && m_payload_byte == '0)
        else $error("result without payload is not a single final item");

    a_payload_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload_length != '0
            |-> m_command >= fucr_pkg::CMD_W'(fucr_pkg::CMD_SET_DATE))
        else $error("payload on an exact command");

    a_stream_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid && m_ready && !m_last
            |-> $stable(m_payload_length) && $stable(m_command))
        else $error("length or command changed inside a payload stream");

endmodule

bind framed_uart_command_recognizer_top fucr_check u_fucr_check (.*);

FILE: tb/command_result_checker.sv
// Channel monitor for the framed command recognizer: predicts every command result and compares it.
module command_result_checker
    import fucr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_rx_byte,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [CMD_W-1:0]     m_command,
    input  logic [PLEN_W-1:0]    m_payload_length,
    input  logic [BYTE_W-1:0]    m_payload_byte,
    input  logic                 m_last,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    output int                   mismatches,
    output int                   replies_due,
    output int                   replies_seen
);

    typedef struct packed {
        cmd_t              command;
        logic [PLEN_W-1:0] plen;
        logic [BYTE_W-1:0] data;
        logic              last;
    } reply_t;

    string cmd_words [NUM_CMDS] = '{
        "led on", "led off", "beep on", "beep off", "get datetime",
        "get alarmtime", "set date", "set time", "set alarm"
    };

    logic [BYTE_W-1:0] open_char;
    logic [BYTE_W-1:0] close_char;
    int                fill;
    logic [BYTE_W-1:0] text_mem [BUFFER_BYTES];
    reply_t            pending_replies [$];

    initial begin
        mismatches   = 0;
        replies_due  = 0;
        replies_seen = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    // first command in table order that fits the stored text, -1 for none
    function automatic int match_command();
        int   c;
        int   i;
        int   n;
        logic ok;
        for (c = 0; c < NUM_CMDS; c++) begin
            n  = cmd_words[c].len();
            ok = 1'b1;
            for (i = 0; i < n; i++) begin
                if (text_mem[i] != cmd_words[c][i]) ok = 1'b0;
            end
            if (c < NUM_EXACT && text_mem[n] != 8'h00) ok = 1'b0;
            if (ok) return c;
        end
        return -1;
    endfunction

    task automatic recognize_byte(input logic [BYTE_W-1:0] b);
        int     hit;
        int     n;
        int     plen;
        int     count;
        int     k;
        reply_t r;
        if (b == open_char) begin
            fill = 1;
        end else if (b != close_char) begin
            if (fill >= 1 && fill <= BUFFER_BYTES) begin
                text_mem[fill-1] = b;
                fill++;
            end
        end else begin
            hit = match_command();
            if (hit >= 0) begin
                n     = cmd_words[hit].len();
                plen  = (hit >= NUM_EXACT && fill > n) ? fill - 1 - n : 0;
                count = (plen == 0) ? 1 : plen;
                for (k = 0; k < count; k++) begin
                    r.command = cmd_t'(hit);
                    r.plen    = PLEN_W'(plen);
                    r.data    = (plen == 0) ? '0 : text_mem[n+k];
                    r.last    = (k == count - 1);
                    pending_replies.push_back(r);
                end
            end
            foreach (text_mem[i]) text_mem[i] = '0;
            fill = 0;
        end
    endtask

    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            open_char  = START_CHAR_RESET;
            close_char = END_CHAR_RESET;
            fill       = 0;
            foreach (text_mem[i]) text_mem[i] = '0;
            pending_replies.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_START_CHAR: open_char = cfg_data;
                    REG_END_CHAR:   close_char = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) recognize_byte(s_rx_byte);
            if (m_valid && m_ready) begin
                replies_seen++;
                if (pending_replies.size() == 0) begin
                    report_mismatch($sformatf("command %0d byte %02h with nothing pending",
                                              m_command, m_payload_byte));
                end else begin
                    want = pending_replies.pop_front();
                    check_field("command", m_command, want.command);
                    check_field("payload_length", m_payload_length, want.plen);
                    check_field("payload_byte", m_payload_byte, want.data);
                    check_field("last", m_last, want.last);
                end
            end
        end
        replies_due = pending_replies.size();
    end

endmodule

FILE: tb/framed_uart_command_recognizer_top_tb.sv
// Testbench top: drives byte frames and register writes into the recognizer and reports the verdict.
module framed_uart_command_recognizer_top_tb;
    import fucr_pkg::*;

    localparam int ITEMS         = 430;
    localparam int HOLD_CYCLES   = 800;
    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT   = 5000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_rx_byte = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [CMD_W-1:0]     m_command;
    logic [PLEN_W-1:0]    m_payload_length;
    logic [BYTE_W-1:0]    m_payload_byte;
    logic                 m_last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_data  = '0;

    int mismatches;
    int replies_due;
    int replies_seen;

    string cmd_words [NUM_CMDS] = '{
        "led on", "led off", "beep on", "beep off", "get datetime",
        "get alarmtime", "set date", "set time", "set alarm"
    };

    logic [BYTE_W-1:0] cur_start = START_CHAR_RESET;
    logic [BYTE_W-1:0] cur_end   = END_CHAR_RESET;
    logic [BYTE_W-1:0] frame_bytes [$];
    bit                tx_idle_on = 1'b1;
    bit                rx_idle_on = 1'b1;
    bit                hold_req   = 1'b0;
    int                items_sent    = 0;
    int                well_formed   = 0;
    int                reg_writes    = 0;
    int                settings_used = 1;

    always #2 aclk = ~aclk;

    framed_uart_command_recognizer_top u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_command        (m_command),
        .m_payload_length (m_payload_length),
        .m_payload_byte   (m_payload_byte),
        .m_last           (m_last),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    command_result_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_command        (m_command),
        .m_payload_length (m_payload_length),
        .m_payload_byte   (m_payload_byte),
        .m_last           (m_last),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .replies_due      (replies_due),
        .replies_seen     (replies_seen)
    );

    // result side: random back-pressure, and a long hold-off when requested
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= !(rx_idle_on && $urandom_range(99) < 37);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [BYTE_W-1:0] free_byte();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom_range(255)); while (b == cur_start || b == cur_end);
        return b;
    endfunction

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        while (tx_idle_on && $urandom_range(99) < 37) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
    endtask

    task automatic add_noise(input int n);
        repeat (n) frame_bytes.push_back(free_byte());
    endtask

    task automatic flush_frame();
        foreach (frame_bytes[i]) push_byte(frame_bytes[i]);
        frame_bytes.delete();
    endtask

    task automatic send_command(input cmd_t c, input int n_payload);
        frame_bytes.push_back(cur_start);
        add_text(cmd_words[c]);
        if (c >= CMD_SET_DATE) begin
            add_noise(n_payload);
        end else if (n_payload > 0) begin
            frame_bytes.push_back(8'h00);
            add_noise(n_payload - 1);
        end
        frame_bytes.push_back(cur_end);
        flush_frame();
    endtask

    task automatic send_random_frame();
        int    pick;
        int    k;
        int    i;
        int    n;
        cmd_t  c;
        string w;
        pick = $urandom_range(99);
        c    = cmd_t'($urandom_range(NUM_CMDS - 1));
        w    = cmd_words[c];
        if (pick < 60) begin
            if (well_formed < NUM_CMDS) c = cmd_t'(well_formed);
            well_formed++;
            if (c >= CMD_SET_DATE)
                n = ($urandom_range(15) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 8);
            else
                n = ($urandom_range(3) == 0) ? $urandom_range(1, 5) : 0;
            send_command(c, n);
        end else if (pick < 70) begin
            frame_bytes.push_back(cur_start);
            add_text(w);
            k = $urandom_range(w.len() - 1);
            case ($urandom_range(2))
                0:       frame_bytes[1 + k] = free_byte();
                1:       repeat (w.len() - k) void'(frame_bytes.pop_back());
                default: add_noise($urandom_range(1, 3));
            endcase
            frame_bytes.push_back(cur_end);
            flush_frame();
        end else if (pick < 80) begin
            // abandon a frame, then close one no longer than it over its stale text
            frame_bytes.push_back(cur_start);
            add_text(w);
            add_noise($urandom_range(0, 3));
            frame_bytes.push_back(cur_start);
            k = $urandom_range(w.len());
            for (i = 0; i < k; i++) frame_bytes.push_back(w[i]);
            frame_bytes.push_back(cur_end);
            flush_frame();
        end else if (pick < 90) begin
            add_noise($urandom_range(1, 6));
            if ($urandom_range(1)) frame_bytes.push_back(cur_end);
            flush_frame();
        end else begin
            frame_bytes.push_back(cur_start);
            add_noise($urandom_range(60, 80));
            frame_bytes.push_back(cur_end);
            flush_frame();
        end
    endtask

    task automatic run_phase(input int n);
        int stop;
        stop = items_sent + n;
        while (items_sent < stop) send_random_frame();
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (replies_due != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [BYTE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        reg_writes++;
        @(negedge aclk);
    endtask

    task automatic set_chars(input logic [BYTE_W-1:0] open_b, input logic [BYTE_W-1:0] close_b);
        settle();
        write_reg(REG_START_CHAR, open_b);
        write_reg(REG_END_CHAR, close_b);
        cfg_valid <= 1'b0;
        cur_start = open_b;
        cur_end   = close_b;
        settings_used++;
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // fill the scanned store positions first, then the edge frames
        frame_bytes.push_back(cur_start);
        add_text(cmd_words[CMD_SET_ALARM]);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'h80);
        frame_bytes.push_back(8'h01);
        frame_bytes.push_back(8'h7F);
        frame_bytes.push_back(cur_end);
        frame_bytes.push_back(cur_end);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(cur_start);
        frame_bytes.push_back(cur_end);
        flush_frame();
        run_phase(40);

        set_chars(8'h00, 8'hFF);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_phase(50);

        set_chars(8'hFF, 8'h00);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_req   = 1'b1;
        send_command(CMD_SET_DATE, 56);
        send_command(CMD_SET_TIME, 56);
        send_command(CMD_SET_ALARM, 55);
        s_valid <= 1'b0;
        do @(negedge aclk); while (replies_due != 0);
        run_phase(30);

        set_chars(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
        run_phase(40);

        set_chars(8'h2A, 8'h2A);
        run_phase(20);

        set_chars(START_CHAR_RESET, END_CHAR_RESET);
        while (items_sent < ITEMS) send_random_frame();
        settle();

        $display("Run covered %0d input bytes and %0d command results over %0d character settings",
                 items_sent, replies_seen, settings_used);
        $display("with %0d register writes, an output hold-off of %0d cycles and a no-idle stretch",
                 reg_writes, HOLD_CYCLES);
        if (mismatches == 0 && replies_due == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/fucr_pkg.sv
rtl/fucr_ram.sv
rtl/fucr_match.sv
rtl/framed_uart_command_recognizer_top.sv
rtl/fucr_check.sv
tb/command_result_checker.sv
tb/framed_uart_command_recognizer_top_tb.sv
